>>> hw/rtl/gff_pkg.sv
// Shared types, constants and helpers of the first-fit grid rectangle allocator.
package gff_pkg;

  // Grid limits
  localparam int MAX_COLUMNS = 16;
  localparam int MAX_LINES   = 16;
  localparam int COL_IDX_W   = $clog2(MAX_COLUMNS);
  localparam int LINE_IDX_W  = $clog2(MAX_LINES);

  // Field widths
  localparam int CNT_W  = 5;   // sizes, scan counters and config values
  localparam int COL_W  = 4;   // column coordinate
  localparam int LINE_W = 10;  // line coordinate

  localparam logic [CNT_W-1:0]  GRID_RESET = CNT_W'(16);
  localparam logic [LINE_W-1:0] LINE_SAT   = '1;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_ALLOC = 2'd1,
    OP_PLACE = 2'd2,
    OP_NOP   = 2'd3
  } gff_op_t;

  typedef enum logic [0:0] {
    REG_COLUMNS = 1'b0,
    REG_LINES   = 1'b1
  } gff_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_COLS,
    ST_MARK,
    ST_DONE
  } gff_state_t;

  typedef struct packed {
    gff_op_t           opcode;
    logic [CNT_W-1:0]  item_width;
    logic [CNT_W-1:0]  item_height;
    logic [COL_W-1:0]  target_col;
    logic [LINE_W-1:0] target_line;
  } gff_req_t;

  typedef struct packed {
    logic              fits;
    logic [COL_W-1:0]  out_col;
    logic [LINE_W-1:0] out_line;
  } gff_res_t;

  typedef struct packed {
    logic [CNT_W-1:0] grid_columns;
    logic [CNT_W-1:0] grid_lines;
  } gff_cfg_t;

  // Row store access: one line address, optional OR of a mask into that row
  typedef struct packed {
    logic [CNT_W-1:0]       addr;
    logic                   or_en;
    logic [MAX_COLUMNS-1:0] or_mask;
  } gff_occ_req_t;

  // Cells col .. col+w-1 of a row; bits past the last store column drop out
  function automatic logic [MAX_COLUMNS-1:0] span_mask(logic [CNT_W-1:0] w,
                                                       logic [CNT_W-1:0] col);
    logic [2*MAX_COLUMNS-1:0] m;
    m = {{MAX_COLUMNS{1'b0}}, {MAX_COLUMNS{1'b1}}} >> (CNT_W'(MAX_COLUMNS) - w);
    m = m << col;
    return m[MAX_COLUMNS-1:0];
  endfunction

endpackage

>>> hw/rtl/gff_occ.sv
// Occupancy bitmap: one row word per line, single address, read and OR-in write.
module gff_occ (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gff_pkg::gff_occ_req_t               occ_req,
  output logic [gff_pkg::MAX_COLUMNS-1:0]     rd_row
);
  import gff_pkg::*;

  logic [MAX_COLUMNS-1:0] rows_r [MAX_LINES];
  logic                   in_grid;

  assign in_grid = occ_req.addr < CNT_W'(MAX_LINES);

  // Read the addressed row; a line past the store reads as free
  assign rd_row = in_grid ? rows_r[occ_req.addr[LINE_IDX_W-1:0]] : '0;

  // Clear on reset, mark cells taken on request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LINES; i++) rows_r[i] <= '0;
    end else if (occ_req.or_en && in_grid) begin
      rows_r[occ_req.addr[LINE_IDX_W-1:0]] <=
        rows_r[occ_req.addr[LINE_IDX_W-1:0]] | occ_req.or_mask;
    end
  end

endmodule

>>> hw/rtl/gff_seq.sv
// Request sequencer: row gather, column scan, marking and stacking mode.
module gff_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gff_pkg::gff_cfg_t     cfg,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  gff_pkg::gff_req_t     req,
  output logic                  res_valid,
  input  logic                  res_ready,
  output gff_pkg::gff_res_t     res,
  output gff_pkg::gff_occ_req_t occ_req,
  input  logic [gff_pkg::MAX_COLUMNS-1:0] rd_row
);
  import gff_pkg::*;

  gff_state_t             state_r, state_nxt;
  gff_op_t                op_r, op_nxt;
  logic [CNT_W-1:0]       w_r, w_nxt, h_r, h_nxt;
  logic [CNT_W-1:0]       cols_r, cols_nxt, lines_r, lines_nxt;
  logic [CNT_W-1:0]       line_r, line_nxt, col_r, col_nxt, k_r, k_nxt;
  logic [CNT_W-1:0]       base_r, base_nxt;
  logic [MAX_COLUMNS-1:0] acc_r, acc_nxt, start_r, start_nxt, mask_r, mask_nxt;
  logic                   fit_r, fit_nxt;
  logic [COL_W-1:0]       res_col_r, res_col_nxt;
  logic [LINE_W-1:0]      res_line_r, res_line_nxt;
  logic [LINE_W-1:0]      stk_line_r, stk_line_nxt;
  logic                   stk_nonempty_r, stk_nonempty_nxt;

  logic [CNT_W-1:0]  in_cols, in_lines;
  logic [LINE_W-1:0] stk_pos;
  logic [LINE_W:0]   stk_sum;
  logic              start_bit, cell_free;
  logic [CNT_W-1:0]  k_inc;

  // Clamp the size registers to the grid store
  assign in_cols  = (cfg.grid_columns > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS)
                                                             : cfg.grid_columns;
  assign in_lines = (cfg.grid_lines > CNT_W'(MAX_LINES)) ? CNT_W'(MAX_LINES)
                                                         : cfg.grid_lines;

  // Stacking position and the next one, a free line below the item
  assign stk_pos = (req.opcode == OP_PLACE) ? req.target_line
                 : (stk_nonempty_r ? stk_line_r : '0);
  assign stk_sum = {1'b0, stk_pos} + (LINE_W+1)'(req.item_height) + (LINE_W+1)'(1);

  // Shared fit test for the current column
  assign start_bit = (col_r < CNT_W'(MAX_COLUMNS)) ? start_r[col_r[COL_IDX_W-1:0]]
                                                    : 1'b0;
  assign cell_free = !start_bit && ((acc_r & span_mask(w_r, col_r)) == '0);
  assign k_inc     = k_r + CNT_W'(1);

  // Row store port
  always_comb begin
    occ_req.addr    = ((state_r == ST_MARK) ? base_r : line_r) + k_r;
    occ_req.or_en   = (state_r == ST_MARK);
    occ_req.or_mask = mask_r;
  end

  assign req_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = '{fits: fit_r, out_col: res_col_r, out_line: res_line_r};

  // Next state and datapath
  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    w_nxt            = w_r;
    h_nxt            = h_r;
    cols_nxt         = cols_r;
    lines_nxt        = lines_r;
    line_nxt         = line_r;
    col_nxt          = col_r;
    k_nxt            = k_r;
    base_nxt         = base_r;
    acc_nxt          = acc_r;
    start_nxt        = start_r;
    mask_nxt         = mask_r;
    fit_nxt          = fit_r;
    res_col_nxt      = res_col_r;
    res_line_nxt     = res_line_r;
    stk_line_nxt     = stk_line_r;
    stk_nonempty_nxt = stk_nonempty_r;

    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          op_nxt       = req.opcode;
          w_nxt        = req.item_width;
          h_nxt        = req.item_height;
          cols_nxt     = in_cols;
          lines_nxt    = in_lines;
          fit_nxt      = 1'b0;
          res_col_nxt  = '0;
          res_line_nxt = '0;
          line_nxt     = '0;
          col_nxt      = '0;
          k_nxt        = '0;
          acc_nxt      = '0;
          state_nxt    = ST_DONE;
          if (req.opcode == OP_NOP) begin
            // no operation: empty result
          end else if (in_cols == '0 || in_lines == '0) begin
            // stacking mode
            fit_nxt      = 1'b1;
            res_col_nxt  = (req.opcode == OP_PLACE) ? req.target_col : '0;
            res_line_nxt = stk_pos;
            if (req.opcode != OP_QUERY) begin
              stk_line_nxt     = stk_sum[LINE_W] ? LINE_SAT : stk_sum[LINE_W-1:0];
              stk_nonempty_nxt = 1'b1;
            end
          end else if (req.opcode == OP_PLACE) begin
            // place: inside the grid, no overlap check
            if (((CNT_W+1)'(req.target_col) + (CNT_W+1)'(req.item_width)
                   <= (CNT_W+1)'(in_cols)) &&
                ((LINE_W+1)'(req.target_line) + (LINE_W+1)'(req.item_height)
                   <= (LINE_W+1)'(in_lines))) begin
              fit_nxt      = 1'b1;
              res_col_nxt  = req.target_col;
              res_line_nxt = req.target_line;
              base_nxt     = req.target_line[CNT_W-1:0];
              mask_nxt     = span_mask(req.item_width, CNT_W'(req.target_col));
              if (req.item_height != '0) state_nxt = ST_MARK;
            end
          end else if (req.item_width <= in_cols && req.item_height <= in_lines) begin
            state_nxt = ST_ACC;
          end
        end
      end

      ST_ACC: begin
        // gather rows line .. line+h-1, keep the starting row apart
        if (k_r == '0) start_nxt = rd_row;
        if (k_r < h_r) acc_nxt = acc_r | rd_row;
        if ((CNT_W+1)'(k_r) + (CNT_W+1)'(1) >= (CNT_W+1)'(h_r)) begin
          col_nxt   = '0;
          state_nxt = ST_COLS;
        end else begin
          k_nxt = k_inc;
        end
      end

      ST_COLS: begin
        if (cell_free) begin
          fit_nxt      = 1'b1;
          res_col_nxt  = col_r[COL_W-1:0];
          res_line_nxt = LINE_W'(line_r);
          base_nxt     = line_r;
          mask_nxt     = span_mask(w_r, col_r);
          k_nxt        = '0;
          state_nxt    = (op_r == OP_ALLOC && h_r != '0) ? ST_MARK : ST_DONE;
        end else if ((CNT_W+1)'(col_r) + (CNT_W+1)'(w_r) >= (CNT_W+1)'(cols_r)) begin
          // last column of this line: advance or give up
          if ((CNT_W+1)'(line_r) + (CNT_W+1)'(1) + (CNT_W+1)'(h_r)
                > (CNT_W+1)'(lines_r)) begin
            state_nxt = ST_DONE;
          end else begin
            line_nxt  = line_r + CNT_W'(1);
            k_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = ST_ACC;
          end
        end else begin
          col_nxt = col_r + CNT_W'(1);
        end
      end

      ST_MARK: begin
        // one row a cycle
        if (k_inc == h_r) state_nxt = ST_DONE;
        else              k_nxt     = k_inc;
      end

      ST_DONE: begin
        if (res_ready) state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      stk_line_r     <= '0;
      stk_nonempty_r <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      stk_line_r     <= stk_line_nxt;
      stk_nonempty_r <= stk_nonempty_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    cols_r     <= cols_nxt;
    lines_r    <= lines_nxt;
    line_r     <= line_nxt;
    col_r      <= col_nxt;
    k_r        <= k_nxt;
    base_r     <= base_nxt;
    acc_r      <= acc_nxt;
    start_r    <= start_nxt;
    mask_r     <= mask_nxt;
    fit_r      <= fit_nxt;
    res_col_r  <= res_col_nxt;
    res_line_r <= res_line_nxt;
  end

  // Marking stays inside the row store
  a_mark_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MARK |-> occ_req.addr < CNT_W'(MAX_LINES))
    else $error("marking past the last line");

  // A miss reports zero coordinates
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !fit_r) |-> (res_col_r == '0 && res_line_r == '0))
    else $error("miss with nonzero coordinates");

  // Column scan never leaves the grid
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COLS |->
      (CNT_W+1)'(col_r) + (CNT_W+1)'(w_r) <= (CNT_W+1)'(cols_r))
    else $error("column scan past grid edge");

  // Row gather only for lines where the rectangle fits
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC |->
      (CNT_W+1)'(line_r) + (CNT_W+1)'(h_r) <= (CNT_W+1)'(lines_r))
    else $error("row gather past grid bottom");

endmodule

>>> hw/rtl/grid_first_fit_rect_allocator.sv
// Top level of the first-fit grid rectangle allocator.
//
// Usage: a request enters on the in_ stream (opcode query, allocate or place,
// rectangle size, place coordinates) and yields exactly one result on the
// out_ stream (fits flag, column, line). Grid size comes from two registers
// written on the cfg_ port (index 0 columns, index 1 lines); either at zero
// switches to stacking mode, where items go one below another, a free line
// apart, at column 0 (a place at its target column). No-op, stacking mode
// and a rejected place go from accept directly to the result; an accepted
// place marks h more rows. Query and allocate scan line by line: each
// tried line first gathers its rows (the starting row alone for a zero
// height) through the single row port, then tries each column in turn in
// the shared fit test; an allocate hit then marks h rows. One request is
// in work at a time; in_tready is low until its result has moved into the
// output register, which holds it while the receiver stalls; the next
// request is taken meanwhile.
// Reset (synchronous, rst_n low) frees every cell, clears the stacking state
// and sets both size registers to 16.
module grid_first_fit_rect_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  // opcode[1:0], item_width[6:2], item_height[11:7], target_col[15:12],
  // target_line[25:16], zero[31:26]
  input  logic [gff_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // fits[0], out_col[4:1], out_line[14:5], zero[15]
  output logic [gff_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [gff_pkg::CNT_W-1:0]         cfg_data
);
  import gff_pkg::*;

  gff_cfg_t               cfg_r;
  gff_req_t               req;
  gff_res_t               res;
  gff_occ_req_t           occ_req;
  logic [MAX_COLUMNS-1:0] rd_row;
  logic                   res_valid, res_ready;
  logic                   out_valid_r;
  gff_res_t               out_res_r;

  // Unpack the request
  assign req = '{opcode:      gff_op_t'(in_tdata[1:0]),
                 item_width:  in_tdata[6:2],
                 item_height: in_tdata[11:7],
                 target_col:  in_tdata[15:12],
                 target_line: in_tdata[25:16]};

  // Size registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_columns <= GRID_RESET;
      cfg_r.grid_lines   <= GRID_RESET;
    end else if (cfg_valid) begin
      case (gff_reg_t'(cfg_index))
        REG_COLUMNS: cfg_r.grid_columns <= cfg_data;
        REG_LINES:   cfg_r.grid_lines   <= cfg_data;
        default: ;
      endcase
    end
  end

  gff_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .occ_req   (occ_req),
    .rd_row    (rd_row)
  );

  gff_occ u_occ (
    .clk     (clk),
    .rst_n   (rst_n),
    .occ_req (occ_req),
    .rd_row  (rd_row)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.out_line, out_res_r.out_col, out_res_r.fits};

  // An accepted request blocks the input until its result is handed over
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after accept");

endmodule
